// ----- rtl/lfu_block_cache_lookup_unit_defines.svh -----
// ----------------------------------------------------------------------------
// LFU block cache lookup assertion macros
// Shared assertion helpers for the block cache lookup unit.
// ----------------------------------------------------------------------------
`ifndef LFU_BLOCK_CACHE_LOOKUP_UNIT_DEFINES_SVH
`define LFU_BLOCK_CACHE_LOOKUP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every clock edge outside of reset.
`define LFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/lfu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU block cache lookup package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned BLOCK_W    = 20;
  localparam int unsigned REG_W      = 21;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned SLOTS_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_LIMIT = 8'd1;

  localparam logic [REG_W-1:0] TOTAL_BLOCKS_RST = 21'd0;
  localparam logic [REG_W-1:0] DIRECT_LIMIT_RST = 21'd1024;

  typedef struct packed {
    logic [REG_W-1:0] total_blocks;
    logic [REG_W-1:0] direct_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SCAN,
    ST_UPDATE
  } lfu_state_e;

endpackage

// ----- rtl/lfu_block_cache_lookup_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU block cache lookup unit
// Sorts disk block requests and keeps a least-frequently-used slot table.
// ----------------------------------------------------------------------------
// A request is taken on start with block_number_i at a clock edge where busy
// is low. Exactly one result follows, shown for one cycle with done_o high.
// A bad or directly mapped block raises done_o from a register set at the end
// of the classify state. A table lookup raises done_o after these steps in
// order: classify, one read of the slot memory per slot, the registered read
// data of the last slot, and the write-back. The scan runs in sequence through
// the single read port of the slot memory. busy is low again in the cycle that
// shows done_o, so the next request may be taken at that edge.
// Configuration is written through cfg_valid_i / cfg_ready_o. The user must
// write it only while idle; the block itself does not enforce this. Index 0
// is the block total, index 1 the direct limit, others are ignored.
// Reset empties every slot and loads the register reset values at once.
// The receiver cannot stall: a result must be taken in the cycle it shows.
// ----------------------------------------------------------------------------
`include "lfu_block_cache_lookup_unit_defines.svh"

module lfu_block_cache_lookup_unit #(
  parameter int unsigned SLOTS = lfu_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lfu_pkg::BLOCK_W-1:0]     block_number_i,
  output logic                            done_o,
  output logic                            bad_block_o,
  output logic                            direct_mapped_o,
  output logic                            hit_o,
  output logic [lfu_pkg::SLOT_OUT_W-1:0]  slot_index_o,
  output logic                            evict_valid_o,
  output logic [lfu_pkg::BLOCK_W-1:0]     evicted_block_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lfu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lfu_pkg::REG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  lfu_pkg::cfg_t               cfg;
  logic                        rd_en, wr_en;
  logic [IDX_W-1:0]            rd_addr, wr_addr;
  logic [lfu_pkg::BLOCK_W-1:0] rd_block, wr_block;
  logic [lfu_pkg::COUNT_W-1:0] rd_count, wr_count;

  lfu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lfu_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_block_o (rd_block),
    .rd_count_o (rd_count),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_block_i (wr_block),
    .wr_count_i (wr_count)
  );

  lfu_lookup_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .block_number_i  (block_number_i),
    .cfg_i           (cfg),
    .busy_o          (busy),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_block_i      (rd_block),
    .rd_count_i      (rd_count),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_block_o      (wr_block),
    .wr_count_o      (wr_count),
    .done_o          (done_o),
    .bad_block_o     (bad_block_o),
    .direct_mapped_o (direct_mapped_o),
    .hit_o           (hit_o),
    .slot_index_o    (slot_index_o),
    .evict_valid_o   (evict_valid_o),
    .evicted_block_o (evicted_block_o)
  );

  `LFU_ASSERT(a_one_class, done_o |-> $onehot0({bad_block_o, direct_mapped_o, hit_o}), "result carries more than one class")
  `LFU_ASSERT(a_evict_on_miss, (done_o && evict_valid_o) |-> (!hit_o && !bad_block_o && !direct_mapped_o), "eviction reported outside a miss")
  `LFU_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `LFU_ASSERT(a_no_write_idle, !busy |-> !wr_en && !rd_en, "slot memory accessed while idle")
  `LFU_ASSERT_ALWAYS(a_single_done, done_o |=> !done_o, "two results in consecutive cycles")

endmodule

// ----- rtl/lfu_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU configuration registers
// Holds the block total and the direct mapping limit.
// ----------------------------------------------------------------------------
module lfu_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lfu_pkg::REG_W-1:0]      cfg_wdata_i,
  output lfu_pkg::cfg_t                  cfg_o
);

  lfu_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Writes to an unknown index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_blocks <= lfu_pkg::TOTAL_BLOCKS_RST;
      cfg_q.direct_limit <= lfu_pkg::DIRECT_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == lfu_pkg::REG_TOTAL_BLOCKS) begin
        cfg_q.total_blocks <= cfg_wdata_i;
      end
      if (cfg_index_i == lfu_pkg::REG_DIRECT_LIMIT) begin
        cfg_q.direct_limit <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- rtl/lfu_slot_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU slot table memory
// One-read one-write slot store with registered read data and valid bits.
// ----------------------------------------------------------------------------
module lfu_slot_mem #(
  parameter int unsigned SLOTS = lfu_pkg::SLOTS_DEF,
  localparam int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [IDX_W-1:0]             rd_addr_i,
  output logic [lfu_pkg::BLOCK_W-1:0]  rd_block_o,
  output logic [lfu_pkg::COUNT_W-1:0]  rd_count_o,
  input  logic                         wr_en_i,
  input  logic [IDX_W-1:0]             wr_addr_i,
  input  logic [lfu_pkg::BLOCK_W-1:0]  wr_block_i,
  input  logic [lfu_pkg::COUNT_W-1:0]  wr_count_i
);

  logic [lfu_pkg::BLOCK_W-1:0] block_mem [SLOTS];
  logic [lfu_pkg::COUNT_W-1:0] count_mem [SLOTS];
  logic [SLOTS-1:0]            valid_q;
  logic                        rd_valid_q;
  logic [lfu_pkg::BLOCK_W-1:0] rd_block_q;
  logic [lfu_pkg::COUNT_W-1:0] rd_count_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      block_mem[wr_addr_i] <= wr_block_i;
      count_mem[wr_addr_i] <= wr_count_i;
    end
    if (rd_en_i) begin
      rd_block_q <= block_mem[rd_addr_i];
      rd_count_q <= count_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // A slot never written reads as empty with a zero count.
  assign rd_block_o = rd_valid_q ? rd_block_q : '0;
  assign rd_count_o = rd_valid_q ? rd_count_q : '0;

endmodule

// ----- rtl/lfu_lookup_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU lookup controller
// Classifies a request; for a table lookup, scans the slot table and writes the chosen slot back.
// ----------------------------------------------------------------------------
module lfu_lookup_ctrl #(
  parameter int unsigned SLOTS = lfu_pkg::SLOTS_DEF,
  localparam int unsigned IDX_W = $clog2(SLOTS),
  localparam int unsigned CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lfu_pkg::BLOCK_W-1:0]     block_number_i,
  input  lfu_pkg::cfg_t                   cfg_i,
  output logic                            busy_o,
  output logic                            rd_en_o,
  output logic [IDX_W-1:0]                rd_addr_o,
  input  logic [lfu_pkg::BLOCK_W-1:0]     rd_block_i,
  input  logic [lfu_pkg::COUNT_W-1:0]     rd_count_i,
  output logic                            wr_en_o,
  output logic [IDX_W-1:0]                wr_addr_o,
  output logic [lfu_pkg::BLOCK_W-1:0]     wr_block_o,
  output logic [lfu_pkg::COUNT_W-1:0]     wr_count_o,
  output logic                            done_o,
  output logic                            bad_block_o,
  output logic                            direct_mapped_o,
  output logic                            hit_o,
  output logic [lfu_pkg::SLOT_OUT_W-1:0]  slot_index_o,
  output logic                            evict_valid_o,
  output logic [lfu_pkg::BLOCK_W-1:0]     evicted_block_o
);

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(SLOTS - 1);

  lfu_pkg::lfu_state_e state_q, state_d;

  logic [lfu_pkg::BLOCK_W-1:0]    blk_q;
  logic [CNT_W-1:0]               iss_q;
  logic                           rvalid_q;
  logic [IDX_W-1:0]               radr_q;
  logic                           hit_q;
  logic [IDX_W-1:0]               hit_idx_q;
  logic [lfu_pkg::COUNT_W-1:0]    hit_cnt_q;
  logic [IDX_W-1:0]               min_idx_q;
  logic [lfu_pkg::COUNT_W-1:0]    min_cnt_q;
  logic [lfu_pkg::BLOCK_W-1:0]    min_blk_q;
  logic                           done_q;
  logic                           res_bad_q, res_direct_q, res_hit_q, res_evict_q;
  logic [lfu_pkg::SLOT_OUT_W-1:0] res_slot_q;
  logic [lfu_pkg::BLOCK_W-1:0]    res_evblk_q;

  logic [lfu_pkg::REG_W-1:0] blk_ext;
  logic                      is_bad, is_direct, scan_last;
  logic                      accept, class_done;
  logic [lfu_pkg::COUNT_W-1:0] hit_cnt_inc;

  assign blk_ext   = lfu_pkg::REG_W'(blk_q);
  assign is_bad    = (blk_q == '0) ||
                     ((cfg_i.total_blocks != '0) && (blk_ext >= cfg_i.total_blocks));
  assign is_direct = blk_ext < cfg_i.direct_limit;
  assign scan_last = rvalid_q && (radr_q == LAST_C);
  assign hit_cnt_inc = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfu_pkg::ST_IDLE:   if (start_i) state_d = lfu_pkg::ST_CLASS;
      lfu_pkg::ST_CLASS:  state_d = (is_bad || is_direct) ? lfu_pkg::ST_IDLE
                                                          : lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN:   if (scan_last) state_d = lfu_pkg::ST_UPDATE;
      lfu_pkg::ST_UPDATE: state_d = lfu_pkg::ST_IDLE;
      default:            state_d = lfu_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy_o     = 1'b1;
    accept     = 1'b0;
    class_done = 1'b0;
    rd_en_o    = 1'b0;
    wr_en_o    = 1'b0;
    case (state_q)
      lfu_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        accept = start_i;
      end
      lfu_pkg::ST_CLASS:  class_done = is_bad || is_direct;
      lfu_pkg::ST_SCAN:   rd_en_o = (iss_q != SLOTS_C);
      lfu_pkg::ST_UPDATE: wr_en_o = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  assign rd_addr_o  = iss_q[IDX_W-1:0];
  assign wr_addr_o  = hit_q ? hit_idx_q : min_idx_q;
  assign wr_block_o = blk_q;
  assign wr_count_o = hit_q ? hit_cnt_inc : lfu_pkg::COUNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lfu_pkg::ST_IDLE;
      iss_q    <= '0;
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rd_en_o;
      done_q   <= class_done || wr_en_o;
      if (state_q == lfu_pkg::ST_CLASS) begin
        iss_q <= '0;
        hit_q <= 1'b0;
      end else if (rd_en_o) begin
        iss_q <= iss_q + 1'b1;
      end
      // Table blocks are unique, so at most one slot can match.
      if (rvalid_q && (rd_block_i == blk_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= block_number_i;
    end
    if (rd_en_o) begin
      radr_q <= rd_addr_o;
    end
    if (rvalid_q) begin
      if (rd_block_i == blk_q) begin
        hit_idx_q <= radr_q;
        hit_cnt_q <= rd_count_i;
      end
      // Strict compare keeps the lowest slot on ties.
      if ((radr_q == '0) || (rd_count_i < min_cnt_q)) begin
        min_idx_q <= radr_q;
        min_cnt_q <= rd_count_i;
        min_blk_q <= rd_block_i;
      end
    end
    if (class_done) begin
      res_bad_q    <= is_bad;
      res_direct_q <= !is_bad;
      res_hit_q    <= 1'b0;
      res_slot_q   <= '0;
      res_evict_q  <= 1'b0;
      res_evblk_q  <= '0;
    end else if (wr_en_o) begin
      res_bad_q    <= 1'b0;
      res_direct_q <= 1'b0;
      res_hit_q    <= hit_q;
      res_slot_q   <= lfu_pkg::SLOT_OUT_W'(wr_addr_o);
      res_evict_q  <= !hit_q && (min_blk_q != '0);
      res_evblk_q  <= hit_q ? '0 : min_blk_q;
    end
  end

  assign done_o          = done_q;
  assign bad_block_o     = res_bad_q;
  assign direct_mapped_o = res_direct_q;
  assign hit_o           = res_hit_q;
  assign slot_index_o    = res_slot_q;
  assign evict_valid_o   = res_evict_q;
  assign evicted_block_o = res_evblk_q;

endmodule
